/* rtl/csbd_pkg.sv */
`timescale 1ns / 1ps
// Shared types and character constants for the character stream byte decoder.
// No dependencies.
package csbd_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned VALUE_W   = 8;
	localparam int unsigned RUN_LEN_W = 5;
	localparam int unsigned HIGH_W    = 3;

	localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
	localparam logic [CH_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CH_W-1:0] CH_CR        = 8'h0D;
	localparam logic [CH_W-1:0] CH_LF        = 8'h0A;
	localparam logic [CH_W-1:0] CH_ZERO      = 8'h30;
	localparam logic [CH_W-1:0] CH_BASE      = 8'h41;
	localparam logic [CH_W-1:0] CH_LOW_BASE  = 8'h47;
	localparam logic [CH_W-1:0] CH_UPPER_MAX = 8'h5A;
	localparam logic [CH_W-1:0] CH_OPEN_MAX  = 8'h6E;
	localparam logic [CH_W-1:0] CH_PAIR_MAX  = 8'h66;
	localparam logic [CH_W-1:0] CH_RUN_BASE  = 8'h40;

	// One queued command: run_len + 1 bytes of value, last on the final one
	typedef struct packed {
		logic [VALUE_W-1:0]   value;
		logic                 err;
		logic [RUN_LEN_W-1:0] run_len;
	} cmd_t;

endpackage

/* rtl/csbd_front.sv */
`timescale 1ns / 1ps
// Front end: accepts characters, tracks pair and run prefixes, issues commands.
// Depends on csbd_pkg.
module csbd_front
	import csbd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  logic [CH_W-1:0] ch,
	output logic            push,
	output cmd_t            push_cmd
);

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RUN  = 2'd1,
		MODE_PAIR = 2'd2
	} mode_t;

	mode_t             mode_q;
	mode_t             mode_d;
	logic [HIGH_W-1:0] high_q;
	logic [HIGH_W-1:0] high_d;
	logic              emit;
	logic [CH_W-1:0]   diff;
	logic              skip;

	assign skip = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR) || (ch == CH_LF);

	always_comb begin
		mode_d   = mode_q;
		high_d   = high_q;
		emit     = 1'b0;
		push_cmd = '0;
		diff     = '0;
		if (!skip) begin
			unique case (mode_q)
				MODE_RUN: begin
					mode_d = MODE_IDLE;
					emit   = 1'b1;
					diff   = ch - CH_RUN_BASE;
					if (ch > CH_UPPER_MAX || ch < CH_RUN_BASE) begin
						push_cmd.err = 1'b1;
					end else begin
						push_cmd.run_len = diff[RUN_LEN_W-1:0];
					end
				end
				MODE_PAIR: begin
					mode_d = MODE_IDLE;
					emit   = 1'b1;
					if (ch > CH_PAIR_MAX) begin
						push_cmd.err = 1'b1;
					end else begin
						diff = (ch > CH_UPPER_MAX) ? ch - CH_LOW_BASE : ch - CH_BASE;
						push_cmd.value = diff | {high_q, {(VALUE_W-HIGH_W){1'b0}}};
					end
				end
				default: begin
					mode_d = MODE_IDLE;
					priority if (ch == CH_ZERO) begin
						mode_d = MODE_RUN;
					end else if (ch > CH_OPEN_MAX) begin
						emit         = 1'b1;
						push_cmd.err = 1'b1;
					end else if (ch > CH_UPPER_MAX) begin
						diff   = ch + 8'd1;
						high_d = diff[HIGH_W-1:0];
						mode_d = MODE_PAIR;
					end else begin
						emit           = 1'b1;
						push_cmd.value = ch - CH_BASE;
					end
				end
			endcase
		end
	end

	assign push = take && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			high_q <= '0;
		end else if (take) begin
			mode_q <= mode_d;
			high_q <= high_d;
		end
	end

endmodule

/* rtl/csbd_queue.sv */
`timescale 1ns / 1ps
// Small command queue between front and back ends.
// Depends on csbd_pkg.
module csbd_queue
	import csbd_pkg::*;
#(
	parameter int unsigned DEPTH = 4
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_FULL);
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/csbd_back.sv */
`timescale 1ns / 1ps
// Back end: expands queued commands into output bytes through an output register.
// Depends on csbd_pkg.
module csbd_back
	import csbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               empty,
	input  cmd_t               head,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [VALUE_W-1:0] m_tdata,
	output logic               m_tuser,
	output logic               m_tlast
);

	logic                 valid_q;
	logic [VALUE_W-1:0]   value_q;
	logic                 err_q;
	logic                 last_q;
	logic [RUN_LEN_W-1:0] idx_q;
	logic                 load;
	logic                 final_byte;

	assign load       = (!valid_q || m_tready) && !empty;
	assign final_byte = (idx_q == head.run_len);
	assign pop        = load && final_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= final_byte ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q <= head.value;
			err_q   <= head.err;
			last_q  <= final_byte;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = err_q;
	assign m_tlast  = last_q;

endmodule

/* rtl/char_stream_byte_decoder.sv */
`timescale 1ns / 1ps
// Character stream byte decoder top level: front end, command queue, back end.
// Depends on csbd_pkg, csbd_front, csbd_queue, csbd_back.
//
// Usage:
//   Slave channel s_*: one character per transfer in s_tdata.
//   Master channel m_*: one decoded byte per transfer; m_tuser flags a
//   decode error (byte then zero), m_tlast marks the final byte a character
//   produces. Whitespace and prefix characters produce no transfer.
//   A producing character enters the queue at its transfer edge and its
//   first byte then goes through the output register onto m_*.
//   Throughput: one character per cycle on the input and one byte per
//   cycle on the output while m_tready is high; a zero run of N bytes holds
//   the back end until all N bytes are out, and the input stalls once the
//   queue of QUEUE_DEPTH commands fills behind it.
//   Reset clears the prefix state, the queue and the output register's valid flag.
//   When m_tready is low the output register holds, the queue fills and
//   s_tready drops only when the queue is full.
module char_stream_byte_decoder
	import csbd_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] value
	output logic       m_tuser,   // [0] decode_error
	output logic       m_tlast
);

	logic take;
	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	logic empty;
	cmd_t head;

	assign s_tready = !full;
	assign take     = s_tvalid && !full;

	csbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ch       (s_tdata),
		.push     (push),
		.push_cmd (push_cmd)
	);

	csbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	csbd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
